@@ sv/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Shared phase codes and constants.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd400;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [14:0] {
        PH_IDLE    = 15'b000000000000001,
        PH_ST1     = 15'b000000000000010,
        PH_ST2     = 15'b000000000000100,
        PH_WB_LOW  = 15'b000000000001000,
        PH_WB_HIGH = 15'b000000000010000,
        PH_WA_LOW  = 15'b000000000100000,
        PH_WA_HIGH = 15'b000000001000000,
        PH_WAIT    = 15'b000000010000000,
        PH_RB_LOW  = 15'b000000100000000,
        PH_RB_HIGH = 15'b000001000000000,
        PH_RA_LOW  = 15'b000010000000000,
        PH_RA_HIGH = 15'b000100000000000,
        PH_SP1     = 15'b001000000000000,
        PH_SP2     = 15'b010000000000000,
        PH_SP3     = 15'b100000000000000
    } t_phase;

    typedef enum logic [1:0] {
        STG_DEV   = 2'd0,
        STG_REG   = 2'd1,
        STG_DATA  = 2'd2,
        STG_DEVRD = 2'd3
    } t_stage;

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_DATA  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [15:0] length;
        logic [7:0]  write_byte;
        logic        sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       data_request;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       read_last;
        logic       done_res;
        logic       status;
    } t_res;

endpackage

@@ sv/i2cm_fifo.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction queue
// Small register queue between front end and bus engine.
// ----------------------------------------------------------------------------
module i2cm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= inc(r_wp);
            end
            if (i_pop && !o_empty) begin
                r_rp <= inc(r_rp);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full) else $error("full dropped without pop");
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("empty left without push");
`endif
endmodule

@@ sv/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// I2C master bus engine
// Phase sequencer: one queued tick per cycle while the result output is not stalled, one result per tick.
// ----------------------------------------------------------------------------
module i2cm_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_phase_ticks,
    input  logic            i_cmd_valid,
    input  i2cm_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_res_valid,
    input  logic            i_res_stall,
    output i2cm_pkg::t_res  o_res
);
    i2cm_pkg::t_phase r_ph, n_ph;
    i2cm_pkg::t_stage r_stg, n_stg;
    logic [3:0]  r_bit, n_bit;
    logic [7:0]  r_sh, n_sh;
    logic [COUNT_WIDTH-1:0] r_left, n_left;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_dev, n_dev, r_reg, n_reg;
    logic        r_rd, n_rd, r_scl, n_scl, r_sda, n_sda, r_nack, n_nack;
    logic        r_ov, fire;
    i2cm_pkg::t_res r_res, n_res;
    logic [15:0] lim;

    assign lim = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;
    assign fire = i_cmd_valid && (!r_ov || !i_res_stall);
    assign o_cmd_pop = fire;
    assign o_res_valid = r_ov;
    assign o_res = r_res;

    always_comb begin
        logic [7:0] v;
        logic       go_en, sb;
        i2cm_pkg::t_phase tgt;
        logic       rv, rl, dn;
        logic [7:0] rb;
        n_ph = r_ph; n_stg = r_stg; n_bit = r_bit; n_sh = r_sh; n_left = r_left;
        n_tick = r_tick; n_dev = r_dev; n_reg = r_reg; n_rd = r_rd;
        n_scl = r_scl; n_sda = r_sda; n_nack = r_nack;
        go_en = 1'b0; sb = 1'b0; v = 8'd0; tgt = i2cm_pkg::PH_IDLE;
        rv = 1'b0; rl = 1'b0; dn = 1'b0; rb = 8'd0;
        case (r_ph)
            i2cm_pkg::PH_IDLE: begin
                if (i_cmd.mode == i2cm_pkg::MODE_WRITE || i_cmd.mode == i2cm_pkg::MODE_READ) begin
                    n_dev = i_cmd.dev_addr;
                    n_reg = i_cmd.reg_addr;
                    n_left = i_cmd.length[COUNT_WIDTH-1:0];
                    n_rd = (i_cmd.mode == i2cm_pkg::MODE_READ);
                    n_nack = 1'b0;
                    n_stg = i2cm_pkg::STG_DEV;
                    go_en = 1'b1; tgt = i2cm_pkg::PH_ST1;
                end
            end
            i2cm_pkg::PH_WAIT: begin
                if (i_cmd.mode == i2cm_pkg::MODE_DATA) begin
                    sb = 1'b1; v = i_cmd.write_byte;
                end
            end
            default: begin
                n_tick = r_tick + 16'd1;
                if (n_tick >= lim) begin
                    case (r_ph)
                        i2cm_pkg::PH_ST1: begin go_en = 1'b1; tgt = i2cm_pkg::PH_ST2; end
                        i2cm_pkg::PH_ST2: begin
                            n_scl = 1'b0; sb = 1'b1;
                            v = (r_stg == i2cm_pkg::STG_DEVRD) ? (r_dev | 8'h01) : r_dev;
                        end
                        i2cm_pkg::PH_WB_LOW: begin go_en = 1'b1; tgt = i2cm_pkg::PH_WB_HIGH; end
                        i2cm_pkg::PH_WB_HIGH: begin
                            n_sh = {r_sh[6:0], 1'b0};
                            n_bit = r_bit + 4'd1;
                            go_en = 1'b1;
                            tgt = (n_bit < 4'd8) ? i2cm_pkg::PH_WB_LOW : i2cm_pkg::PH_WA_LOW;
                        end
                        i2cm_pkg::PH_WA_LOW: begin go_en = 1'b1; tgt = i2cm_pkg::PH_WA_HIGH; end
                        i2cm_pkg::PH_WA_HIGH: begin
                            n_scl = 1'b0;
                            go_en = 1'b1;
                            if (i_cmd.sda_in) begin
                                n_nack = 1'b1; tgt = i2cm_pkg::PH_SP1;
                            end else if (r_stg == i2cm_pkg::STG_DEV) begin
                                n_stg = i2cm_pkg::STG_REG; go_en = 1'b0; sb = 1'b1; v = r_reg;
                            end else if (r_stg == i2cm_pkg::STG_REG) begin
                                if (r_rd) begin
                                    n_stg = i2cm_pkg::STG_DEVRD; tgt = i2cm_pkg::PH_ST1;
                                end else begin
                                    n_stg = i2cm_pkg::STG_DATA;
                                    tgt = (r_left == '0) ? i2cm_pkg::PH_SP1 : i2cm_pkg::PH_WAIT;
                                end
                            end else if (r_stg == i2cm_pkg::STG_DATA) begin
                                n_left = r_left - 1'b1;
                                tgt = (n_left == '0) ? i2cm_pkg::PH_SP1 : i2cm_pkg::PH_WAIT;
                            end else if (r_left == '0) begin
                                tgt = i2cm_pkg::PH_SP1;
                            end else begin
                                n_sh = 8'd0; n_bit = 4'd0; tgt = i2cm_pkg::PH_RB_LOW;
                            end
                        end
                        i2cm_pkg::PH_RB_LOW: begin go_en = 1'b1; tgt = i2cm_pkg::PH_RB_HIGH; end
                        i2cm_pkg::PH_RB_HIGH: begin
                            n_sh = {r_sh[6:0], i_cmd.sda_in};
                            n_bit = r_bit + 4'd1;
                            go_en = 1'b1;
                            tgt = (n_bit < 4'd8) ? i2cm_pkg::PH_RB_LOW : i2cm_pkg::PH_RA_LOW;
                        end
                        i2cm_pkg::PH_RA_LOW: begin go_en = 1'b1; tgt = i2cm_pkg::PH_RA_HIGH; end
                        i2cm_pkg::PH_RA_HIGH: begin
                            n_scl = 1'b0; n_sda = 1'b1;
                            rb = r_sh; rv = 1'b1;
                            rl = (r_left <= COUNT_WIDTH'(1));
                            n_left = r_left - 1'b1;
                            go_en = 1'b1;
                            if (rl) begin
                                tgt = i2cm_pkg::PH_SP1;
                            end else begin
                                n_sh = 8'd0; n_bit = 4'd0; tgt = i2cm_pkg::PH_RB_LOW;
                            end
                        end
                        i2cm_pkg::PH_SP1: begin go_en = 1'b1; tgt = i2cm_pkg::PH_SP2; end
                        i2cm_pkg::PH_SP2: begin go_en = 1'b1; tgt = i2cm_pkg::PH_SP3; end
                        i2cm_pkg::PH_SP3: begin dn = 1'b1; go_en = 1'b1; tgt = i2cm_pkg::PH_IDLE; end
                        default: begin go_en = 1'b1; tgt = i2cm_pkg::PH_IDLE; end
                    endcase
                end
            end
        endcase
        if (sb) begin
            n_sh = v; n_bit = 4'd0; go_en = 1'b1; tgt = i2cm_pkg::PH_WB_LOW;
        end
        if (go_en) begin
            n_ph = tgt;
            n_tick = 16'd0;
            case (tgt)
                i2cm_pkg::PH_ST1:     begin n_sda = 1'b1; n_scl = 1'b1; end
                i2cm_pkg::PH_ST2:     n_sda = 1'b0;
                i2cm_pkg::PH_WB_LOW:  begin n_scl = 1'b0; n_sda = n_sh[7]; end
                i2cm_pkg::PH_WA_LOW, i2cm_pkg::PH_WAIT, i2cm_pkg::PH_RB_LOW: begin
                    n_scl = 1'b0; n_sda = 1'b1;
                end
                i2cm_pkg::PH_RA_LOW:  begin
                    n_scl = 1'b0; n_sda = (n_left > COUNT_WIDTH'(1)) ? 1'b0 : 1'b1;
                end
                i2cm_pkg::PH_SP1:     begin n_scl = 1'b0; n_sda = 1'b0; end
                i2cm_pkg::PH_SP3:     n_sda = 1'b1;
                i2cm_pkg::PH_IDLE:    begin n_scl = 1'b1; n_sda = 1'b1; end
                default:              n_scl = 1'b1;
            endcase
        end
        n_res.scl_out = n_scl;
        n_res.sda_out = n_sda;
        n_res.busy_res = (n_ph != i2cm_pkg::PH_IDLE);
        n_res.data_request = (n_ph == i2cm_pkg::PH_WAIT);
        n_res.read_byte = rb;
        n_res.read_valid = rv;
        n_res.read_last = rl;
        n_res.done_res = dn;
        n_res.status = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
        end
        if (!i_rst_n) begin
            r_ph <= i2cm_pkg::PH_IDLE; r_stg <= i2cm_pkg::STG_DEV;
            r_bit <= '0; r_sh <= '0; r_left <= '0; r_tick <= '0;
            r_dev <= '0; r_reg <= '0; r_rd <= 1'b0;
            r_scl <= 1'b1; r_sda <= 1'b1; r_nack <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (fire) begin
                r_ph <= n_ph; r_stg <= n_stg; r_bit <= n_bit; r_sh <= n_sh;
                r_left <= n_left; r_tick <= n_tick; r_dev <= n_dev; r_reg <= n_reg;
                r_rd <= n_rd; r_scl <= n_scl; r_sda <= n_sda; r_nack <= n_nack;
                r_ov <= 1'b1;
            end else if (!i_res_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_ph_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_ph)) else $error("phase not one-hot");
    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == i2cm_pkg::PH_IDLE) |-> (r_scl && r_sda)) else $error("idle bus driven");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= 4'd8) else $error("bit index overrun");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_res_stall) |=> $stable(r_res)) else $error("stalled result changed");
`endif
endmodule

@@ sv/i2c_master_register_transfer.sv @@
// A tick's result passes through the queue and then the engine's result register.
// Throughput: one tick per cycle while the result output is not stalled.
// Reset: synchronous active-low; engine idle with scl and sda high, phase_ticks 400; result register not reset.
// ----------------------------------------------------------------------------
// I2C master register transfer
// Front end queues ticks; the bus engine steps the phase sequence.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer #(
    parameter int COUNT_WIDTH = i2cm_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_dev_addr,
    input  logic [7:0]  i_reg_addr,
    input  logic [15:0] i_length,
    input  logic [7:0]  i_write_byte,
    input  logic        i_sda_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_scl_out,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_data_request,
    output logic [7:0]  o_read_byte,
    output logic        o_read_valid,
    output logic        o_read_last,
    output logic        o_done_res,
    output logic        o_status
);
    logic [15:0] r_phase_ticks;
    i2cm_pkg::t_cmd in_cmd, q_cmd;
    i2cm_pkg::t_res res;
    logic full, empty, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2cm_pkg::PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    assign in_cmd = '{mode: i_mode, dev_addr: i_dev_addr, reg_addr: i_reg_addr,
                      length: i_length, write_byte: i_write_byte, sda_in: i_sda_in};
    assign o_stall = full;

    i2cm_fifo #(.WIDTH($bits(i2cm_pkg::t_cmd)), .DEPTH(i2cm_pkg::FIFO_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_valid), .i_data(in_cmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_data(q_cmd)
    );

    i2cm_engine #(.COUNT_WIDTH(COUNT_WIDTH)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_phase_ticks(r_phase_ticks),
        .i_cmd_valid(!empty), .i_cmd(q_cmd), .o_cmd_pop(pop),
        .o_res_valid(o_valid), .i_res_stall(i_stall), .o_res(res)
    );

    assign o_scl_out      = res.scl_out;
    assign o_sda_out      = res.sda_out;
    assign o_busy_res     = res.busy_res;
    assign o_data_request = res.data_request;
    assign o_read_byte    = res.read_byte;
    assign o_read_valid   = res.read_valid;
    assign o_read_last    = res.read_last;
    assign o_done_res     = res.done_res;
    assign o_status       = res.status;
endmodule

@@ tb/sv/i2c_master_register_transfer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register transfer checker
// Watches the tick and result channels, steps its own copy of the bus
// sequencer for every accepted tick and compares each result field by field.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data,
    input  logic           i_valid,
    input  logic           i_stall_in,
    input  logic [1:0]     i_mode,
    input  logic [7:0]     i_dev_addr,
    input  logic [7:0]     i_reg_addr,
    input  logic [15:0]    i_length,
    input  logic [7:0]     i_write_byte,
    input  logic           i_sda_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  i2cm_pkg::t_res i_res,
    output int             o_errors,
    output int             o_pending,
    output logic           o_last_busy,
    output int             o_checked,
    output int             o_transfers,
    output int             o_rx_bytes
);

    i2cm_pkg::t_res   expected_q[$];
    i2cm_pkg::t_phase ph;
    i2cm_pkg::t_stage stg;
    logic [3:0]  bidx;
    logic [7:0]  shreg;
    logic [15:0] left;
    logic [15:0] tcnt;
    logic [15:0] ticks_cfg;
    logic [7:0]  dev;
    logic [7:0]  rgad;
    logic        rd;
    logic        scl;
    logic        sda;
    logic        nack;

    assign o_pending = expected_q.size();

    task automatic enter_phase(input i2cm_pkg::t_phase p);
        ph = p;
        tcnt = '0;
        case (p)
            i2cm_pkg::PH_ST1: begin
                sda = 1'b1;
                scl = 1'b1;
            end
            i2cm_pkg::PH_ST2: sda = 1'b0;
            i2cm_pkg::PH_WB_LOW: begin
                scl = 1'b0;
                sda = shreg[7];
            end
            i2cm_pkg::PH_WB_HIGH, i2cm_pkg::PH_WA_HIGH, i2cm_pkg::PH_RB_HIGH,
            i2cm_pkg::PH_RA_HIGH, i2cm_pkg::PH_SP2: scl = 1'b1;
            i2cm_pkg::PH_WA_LOW, i2cm_pkg::PH_WAIT, i2cm_pkg::PH_RB_LOW: begin
                scl = 1'b0;
                sda = 1'b1;
            end
            i2cm_pkg::PH_RA_LOW: begin
                scl = 1'b0;
                sda = (left > 16'd1) ? 1'b0 : 1'b1;
            end
            i2cm_pkg::PH_SP1: begin
                scl = 1'b0;
                sda = 1'b0;
            end
            i2cm_pkg::PH_SP3: sda = 1'b1;
            default: begin
                ph = i2cm_pkg::PH_IDLE;
                scl = 1'b1;
                sda = 1'b1;
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] v);
        shreg = v;
        bidx = '0;
        enter_phase(i2cm_pkg::PH_WB_LOW);
    endtask

    task automatic start_rx_byte();
        shreg = '0;
        bidx = '0;
        enter_phase(i2cm_pkg::PH_RB_LOW);
    endtask

    task automatic reset_engine();
        ph = i2cm_pkg::PH_IDLE;
        stg = i2cm_pkg::STG_DEV;
        bidx = '0;
        shreg = '0;
        left = '0;
        tcnt = '0;
        ticks_cfg = i2cm_pkg::PHASE_TICKS_RST;
        dev = '0;
        rgad = '0;
        rd = 1'b0;
        scl = 1'b1;
        sda = 1'b1;
        nack = 1'b0;
    endtask

    task automatic step_bus(input i2cm_pkg::t_cmd c, output i2cm_pkg::t_res r);
        logic [15:0] lim;
        logic        last;
        r = '0;
        lim = (ticks_cfg == 16'd0) ? 16'd1 : ticks_cfg;
        if (ph == i2cm_pkg::PH_IDLE) begin
            if (c.mode == i2cm_pkg::MODE_WRITE || c.mode == i2cm_pkg::MODE_READ) begin
                dev = c.dev_addr;
                rgad = c.reg_addr;
                left = c.length;
                rd = (c.mode == i2cm_pkg::MODE_READ);
                nack = 1'b0;
                stg = i2cm_pkg::STG_DEV;
                enter_phase(i2cm_pkg::PH_ST1);
            end
        end else if (ph == i2cm_pkg::PH_WAIT) begin
            if (c.mode == i2cm_pkg::MODE_DATA) send_byte(c.write_byte);
        end else begin
            tcnt = tcnt + 16'd1;
            if (tcnt >= lim) begin
                case (ph)
                    i2cm_pkg::PH_ST1: enter_phase(i2cm_pkg::PH_ST2);
                    i2cm_pkg::PH_ST2: begin
                        scl = 1'b0;
                        send_byte(stg == i2cm_pkg::STG_DEVRD ? (dev | 8'h01) : dev);
                    end
                    i2cm_pkg::PH_WB_LOW: enter_phase(i2cm_pkg::PH_WB_HIGH);
                    i2cm_pkg::PH_WB_HIGH: begin
                        shreg = shreg << 1;
                        bidx = bidx + 4'd1;
                        enter_phase(bidx < 4'd8 ? i2cm_pkg::PH_WB_LOW : i2cm_pkg::PH_WA_LOW);
                    end
                    i2cm_pkg::PH_WA_LOW: enter_phase(i2cm_pkg::PH_WA_HIGH);
                    i2cm_pkg::PH_WA_HIGH: begin
                        scl = 1'b0;
                        if (c.sda_in) begin
                            nack = 1'b1;
                            enter_phase(i2cm_pkg::PH_SP1);
                        end else if (stg == i2cm_pkg::STG_DEV) begin
                            stg = i2cm_pkg::STG_REG;
                            send_byte(rgad);
                        end else if (stg == i2cm_pkg::STG_REG) begin
                            if (rd) begin
                                stg = i2cm_pkg::STG_DEVRD;
                                enter_phase(i2cm_pkg::PH_ST1);
                            end else begin
                                stg = i2cm_pkg::STG_DATA;
                                enter_phase(left == 16'd0 ? i2cm_pkg::PH_SP1 : i2cm_pkg::PH_WAIT);
                            end
                        end else if (stg == i2cm_pkg::STG_DATA) begin
                            left = left - 16'd1;
                            enter_phase(left == 16'd0 ? i2cm_pkg::PH_SP1 : i2cm_pkg::PH_WAIT);
                        end else if (left == 16'd0) begin
                            enter_phase(i2cm_pkg::PH_SP1);
                        end else begin
                            start_rx_byte();
                        end
                    end
                    i2cm_pkg::PH_RB_LOW: enter_phase(i2cm_pkg::PH_RB_HIGH);
                    i2cm_pkg::PH_RB_HIGH: begin
                        shreg = {shreg[6:0], c.sda_in};
                        bidx = bidx + 4'd1;
                        enter_phase(bidx < 4'd8 ? i2cm_pkg::PH_RB_LOW : i2cm_pkg::PH_RA_LOW);
                    end
                    i2cm_pkg::PH_RA_LOW: enter_phase(i2cm_pkg::PH_RA_HIGH);
                    i2cm_pkg::PH_RA_HIGH: begin
                        scl = 1'b0;
                        sda = 1'b1;
                        r.read_byte = shreg;
                        r.read_valid = 1'b1;
                        last = (left <= 16'd1);
                        r.read_last = last;
                        left = left - 16'd1;
                        if (last) enter_phase(i2cm_pkg::PH_SP1);
                        else start_rx_byte();
                    end
                    i2cm_pkg::PH_SP1: enter_phase(i2cm_pkg::PH_SP2);
                    i2cm_pkg::PH_SP2: enter_phase(i2cm_pkg::PH_SP3);
                    i2cm_pkg::PH_SP3: begin
                        r.done_res = 1'b1;
                        enter_phase(i2cm_pkg::PH_IDLE);
                    end
                    default: enter_phase(i2cm_pkg::PH_IDLE);
                endcase
            end
        end
        r.scl_out = scl;
        r.sda_out = sda;
        r.busy_res = (ph != i2cm_pkg::PH_IDLE);
        r.data_request = (ph == i2cm_pkg::PH_WAIT);
        r.status = nack;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        o_transfers = 0;
        o_rx_bytes = 0;
        o_last_busy = 1'b0;
        reset_engine();
    end

    always @(posedge i_clk) begin
        i2cm_pkg::t_cmd c;
        i2cm_pkg::t_res r;
        i2cm_pkg::t_res e;
        if (!i_rst_n) begin
            reset_engine();
            expected_q.delete();
        end else begin
            if (i_cfg_we) ticks_cfg = i_cfg_data;
            if (i_valid && !i_stall_in) begin
                c = '{i_mode, i_dev_addr, i_reg_addr, i_length, i_write_byte, i_sda_in};
                step_bus(c, r);
                expected_q.push_back(r);
            end
            if (i_out_valid && !i_out_stall) begin
                o_last_busy = i_res.busy_res;
                o_checked++;
                if (i_res.done_res) o_transfers++;
                if (i_res.read_valid) o_rx_bytes++;
                if (expected_q.size() == 0) begin
                    $error("result transaction with no tick outstanding");
                    o_errors++;
                end else begin
                    e = expected_q.pop_front();
                    check_field("scl_out", 8'(e.scl_out), 8'(i_res.scl_out));
                    check_field("sda_out", 8'(e.sda_out), 8'(i_res.sda_out));
                    check_field("busy_res", 8'(e.busy_res), 8'(i_res.busy_res));
                    check_field("data_request", 8'(e.data_request),
                                8'(i_res.data_request));
                    check_field("read_byte", e.read_byte, i_res.read_byte);
                    check_field("read_valid", 8'(e.read_valid), 8'(i_res.read_valid));
                    check_field("read_last", 8'(e.read_last), 8'(i_res.read_last));
                    check_field("done_res", 8'(e.done_res), 8'(i_res.done_res));
                    check_field("status", 8'(e.status), 8'(i_res.status));
                end
            end
        end
    end

endmodule

@@ tb/sv/i2c_master_register_transfer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register transfer testbench
// Drives write and read transfers tick by tick with random ACK/NACK and data
// levels over several phase settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_test;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_cfg_we;
    logic [15:0]    i_cfg_data;
    logic           i_valid;
    logic           o_stall;
    logic [1:0]     i_mode;
    logic [7:0]     i_dev_addr;
    logic [7:0]     i_reg_addr;
    logic [15:0]    i_length;
    logic [7:0]     i_write_byte;
    logic           i_sda_in;
    logic           o_valid;
    logic           i_stall;
    i2cm_pkg::t_res res;
    int             errors;
    int             pending;
    logic           last_busy;
    int             checked;
    int             transfers;
    int             rx_bytes;
    int             snd_idle_pct;
    int             rcv_idle_pct;
    int             hold_cycles;
    int             rand_items;

    i2c_master_register_transfer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_dev_addr     (i_dev_addr),
        .i_reg_addr     (i_reg_addr),
        .i_length       (i_length),
        .i_write_byte   (i_write_byte),
        .i_sda_in       (i_sda_in),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_scl_out      (res.scl_out),
        .o_sda_out      (res.sda_out),
        .o_busy_res     (res.busy_res),
        .o_data_request (res.data_request),
        .o_read_byte    (res.read_byte),
        .o_read_valid   (res.read_valid),
        .o_read_last    (res.read_last),
        .o_done_res     (res.done_res),
        .o_status       (res.status)
    );

    i2c_master_register_transfer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_mode       (i_mode),
        .i_dev_addr   (i_dev_addr),
        .i_reg_addr   (i_reg_addr),
        .i_length     (i_length),
        .i_write_byte (i_write_byte),
        .i_sda_in     (i_sda_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_res        (res),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_last_busy  (last_busy),
        .o_checked    (checked),
        .o_transfers  (transfers),
        .o_rx_bytes   (rx_bytes)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

    // receiver side: random stall, or a long counted hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    task automatic push(input logic [1:0] m, input logic [7:0] da, ra,
                        input logic [15:0] len, input logic [7:0] wb, input logic sd);
        logic st;
        i_valid <= 1'b1;
        i_mode <= m;
        i_dev_addr <= da;
        i_reg_addr <= ra;
        i_length <= len;
        i_write_byte <= wb;
        i_sda_in <= sd;
        do begin
            @(negedge i_clk);
            st = o_stall;
            @(posedge i_clk);
        end while (st);
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // ticks with random data level; sda_in is high with the given percentage
    task automatic ticks(input int n, input logic [1:0] m, input int high_pct);
        repeat (n) push(m, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                        $urandom_range(0, 99) < high_pct);
    endtask

    // sender goes quiet until every result has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // finish any transfer: NACK it and keep supplying bytes until idle
    task automatic settle();
        forever begin
            drain();
            repeat (6) @(posedge i_clk);
            if (!last_busy) break;
            ticks(40, i2cm_pkg::MODE_DATA, 100);
        end
    endtask

    task automatic write_cfg(input logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_phase_ticks(input logic [15:0] v);
        settle();
        write_cfg(v);
    endtask

    task automatic random_transfer();
        logic        is_rd;
        logic [15:0] len;
        is_rd = 1'($urandom_range(0, 1));
        len = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        if ($urandom_range(0, 11) == 0) begin
            is_rd = 1'b0;
            len = 16'($urandom);
        end
        push(is_rd ? i2cm_pkg::MODE_READ : i2cm_pkg::MODE_WRITE, 8'($urandom),
             8'($urandom), len, 8'($urandom), 1'($urandom_range(0, 1)));
        rand_items++;
        repeat ($urandom_range(30, 80)) begin
            case ($urandom_range(0, 19))
                0: push(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                        8'($urandom), 1'($urandom));
                1, 2, 3, 4, 5: push(i2cm_pkg::MODE_DATA, 8'h00, 8'h00, 16'h0, 8'($urandom),
                                    $urandom_range(0, 99) < 8);
                default: push(i2cm_pkg::MODE_TICK, 8'($urandom), 8'($urandom),
                              16'($urandom), 8'($urandom),
                              $urandom_range(0, 99) < (is_rd ? 45 : 8));
            endcase
            rand_items++;
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= 16'd0;
        i_valid <= 1'b0;
        i_mode <= i2cm_pkg::MODE_TICK;
        i_dev_addr <= 8'd0;
        i_reg_addr <= 8'd0;
        i_length <= 16'd0;
        i_write_byte <= 8'd0;
        i_sda_in <= 1'b1;
        snd_idle_pct = 12;
        rcv_idle_pct = 52;
        hold_cycles = 0;
        rand_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset phase length: write started, then the phase is cut short
        ticks(3, i2cm_pkg::MODE_DATA, 50);
        push(i2cm_pkg::MODE_WRITE, 8'hFF, 8'h00, 16'hFFFF, 8'h00, 1'b1);
        push(i2cm_pkg::MODE_READ, 8'h00, 8'hFF, 16'h0000, 8'h00, 1'b1);
        ticks(20, i2cm_pkg::MODE_TICK, 100);
        drain();
        write_cfg(16'd0);

        // zero phase setting runs as one tick per phase
        set_phase_ticks(16'd0);
        push(i2cm_pkg::MODE_WRITE, 8'h00, 8'hFF, 16'd2, 8'h00, 1'b0);
        ticks(45, i2cm_pkg::MODE_TICK, 0);
        push(i2cm_pkg::MODE_DATA, 8'h00, 8'h00, 16'd0, 8'h00, 1'b0);
        push(i2cm_pkg::MODE_DATA, 8'h00, 8'h00, 16'd0, 8'hFF, 1'b0);
        ticks(20, i2cm_pkg::MODE_TICK, 0);
        push(i2cm_pkg::MODE_DATA, 8'h00, 8'h00, 16'd0, 8'hFF, 1'b0);
        ticks(30, i2cm_pkg::MODE_TICK, 0);
        push(i2cm_pkg::MODE_WRITE, 8'hA0, 8'h5A, 16'd0, 8'h00, 1'b0);
        ticks(60, i2cm_pkg::MODE_TICK, 0);
        push(i2cm_pkg::MODE_READ, 8'hA0, 8'h00, 16'd0, 8'h00, 1'b0);
        ticks(80, i2cm_pkg::MODE_TICK, 0);
        push(i2cm_pkg::MODE_READ, 8'h3C, 8'h81, 16'd2, 8'h00, 1'b0);
        ticks(75, i2cm_pkg::MODE_TICK, 0);
        ticks(25, i2cm_pkg::MODE_TICK, 100);

        // sender pauses until everything has come back
        drain();
        set_phase_ticks(16'hFFFF);
        ticks(10, i2cm_pkg::MODE_DATA, 50);
        ticks(10, i2cm_pkg::MODE_TICK, 50);

        set_phase_ticks(16'd1);
        rand_items = 0;
        while (rand_items < 55) random_transfer();
        snd_idle_pct = 52;
        rcv_idle_pct = 12;
        set_phase_ticks(16'd2);
        rand_items = 0;
        while (rand_items < 55) random_transfer();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        set_phase_ticks(16'd3);
        hold_cycles = 300;
        rand_items = 0;
        while (rand_items < 55) random_transfer();

        settle();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d results: %0d transfers done, %0d bytes read.",
                 checked, transfers, rx_bytes);
        $display("Phase lengths 400, 0, 65535, 1, 2, 3 under three idling mixes.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/i2cm_pkg.sv
sv/i2cm_fifo.sv
sv/i2cm_engine.sv
sv/i2c_master_register_transfer.sv
tb/sv/i2c_master_register_transfer_checker.sv
tb/sv/i2c_master_register_transfer_test.sv
